// ===== rtl/onb_pkg.sv =====
// Shared types and constants for the orthonormal basis unit.
package onb_pkg;

  // Cross product operands are cut down to magnitudes below 2^RED_W.
  localparam int RED_W   = 30;
  // Signed cross product width: two products of (RED_W+1)-bit operands and a difference.
  localparam int CROSS_W = 2 * RED_W + 3;
  // Magnitude width of a cross product component.
  localparam int MAG_W   = CROSS_W - 1;
  // Bits needed to hold the bit length of a magnitude.
  localparam int LEN_W   = 6;
  // Normalized magnitudes lie in [2^(UNIT_W-1), 2^UNIT_W).
  localparam int UNIT_W  = 31;
  // Sum of three squares and its integer square root.
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = 32;
  // Pipeline depth of the cross product unit.
  localparam int CROSS_LAT = 4;

  typedef logic signed [CROSS_W-1:0] cross_t;

  typedef struct packed {
    logic   valid;
    cross_t x;
    cross_t y;
    cross_t z;
  } cross_bus_t;

  typedef enum logic [1:0] {
    REG_UP_X = 2'd0,
    REG_UP_Y = 2'd1,
    REG_UP_Z = 2'd2
  } cfg_reg_t;

endpackage

// ===== rtl/orthonormal_basis_from_up_unit.sv =====
// Top level of the orthonormal basis unit: builds right and upward axes from a forward axis.
//
// The unit takes one forward vector word per clock and returns one result word holding
// the normalized right axis (up x forward), the normalized upward axis (forward x right),
// the forward vector unchanged and a degenerate flag. The pipeline depth comes from the
// two normalizers, each of which runs a square root of 32 stages and a divider of
// FRAC_BITS+1 stages, one bit per stage; the two cross products add four stages each.
// busy never rises, so a word is taken every cycle that start is high, and out_valid
// marks each result for exactly one cycle, in the order the words came in. Results
// cannot be held off by the receiver. The up vector registers are written through
// the cfg port and should only change while no word is in flight.
module orthonormal_basis_from_up_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [DATA_WIDTH-1:0] in_fwd_x,
  input  logic [DATA_WIDTH-1:0] in_fwd_y,
  input  logic [DATA_WIDTH-1:0] in_fwd_z,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_wdata,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_right_x,
  output logic [DATA_WIDTH-1:0] out_right_y,
  output logic [DATA_WIDTH-1:0] out_right_z,
  output logic [DATA_WIDTH-1:0] out_upward_x,
  output logic [DATA_WIDTH-1:0] out_upward_y,
  output logic [DATA_WIDTH-1:0] out_upward_z,
  output logic [DATA_WIDTH-1:0] out_fwd_out_x,
  output logic [DATA_WIDTH-1:0] out_fwd_out_y,
  output logic [DATA_WIDTH-1:0] out_fwd_out_z,
  output logic                  out_degenerate
);

  localparam int DW       = DATA_WIDTH;
  localparam int VEC_W    = 3 * DW;
  localparam int SIDE2_W  = 2 * VEC_W + 1;
  localparam int NORM_LAT = 39 + FRAC_BITS;
  localparam int LAT      = 2 * (onb_pkg::CROSS_LAT + NORM_LAT);

  // The pipeline never stalls, so the unit is always ready for another word.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Up vector registers; reset to the unit Y axis.
  logic [DW-1:0] up_x_r, up_y_r, up_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_x_r <= '0;
      up_y_r <= DW'(1) << FRAC_BITS;
      up_z_r <= '0;
    end else if (cfg_we) begin
      case (onb_pkg::cfg_reg_t'(cfg_index))
        onb_pkg::REG_UP_X: up_x_r <= cfg_wdata;
        onb_pkg::REG_UP_Y: up_y_r <= cfg_wdata;
        onb_pkg::REG_UP_Z: up_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // First cross product: up x forward. The forward vector rides along as sideband.
  logic [2:0][DW-1:0]  fwd_in;
  logic [2:0][DW-1:0]  up_vec;
  onb_pkg::cross_bus_t c1_bus;
  logic [VEC_W-1:0]    c1_side;

  assign fwd_in = {in_fwd_z, in_fwd_y, in_fwd_x};
  assign up_vec = {up_z_r, up_y_r, up_x_r};

  onb_cross #(.IW(DW), .SIDE_W(VEC_W)) u_cross_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_a     (up_vec),
    .in_b     (fwd_in),
    .in_side  (fwd_in),
    .out_bus  (c1_bus),
    .out_side (c1_side)
  );

  // Normalize to get the right axis.
  logic               n1_valid;
  logic [2:0][DW-1:0] right_vec;
  logic               n1_zero;
  logic [VEC_W-1:0]   n1_side;

  onb_norm #(.DW(DW), .FB(FRAC_BITS), .SIDE_W(VEC_W)) u_norm_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (c1_bus),
    .in_side  (c1_side),
    .out_valid(n1_valid),
    .out_vec  (right_vec),
    .out_zero (n1_zero),
    .out_side (n1_side)
  );

  // Second cross product: forward x right, built from the saturated right axis.
  // A null right axis gives a null product, so the upward axis is then zero too.
  onb_pkg::cross_bus_t c2_bus;
  logic [SIDE2_W-1:0]  c2_side;

  onb_cross #(.IW(DW), .SIDE_W(SIDE2_W)) u_cross_upward (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (n1_valid),
    .in_a     (n1_side),
    .in_b     (right_vec),
    .in_side  ({n1_zero, right_vec, n1_side}),
    .out_bus  (c2_bus),
    .out_side (c2_side)
  );

  logic               n2_valid;
  logic [2:0][DW-1:0] upward_vec;
  logic               n2_zero;
  logic [SIDE2_W-1:0] n2_side;

  onb_norm #(.DW(DW), .FB(FRAC_BITS), .SIDE_W(SIDE2_W)) u_norm_upward (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (c2_bus),
    .in_side  (c2_side),
    .out_valid(n2_valid),
    .out_vec  (upward_vec),
    .out_zero (n2_zero),
    .out_side (n2_side)
  );

  // Every output comes from the last pipeline registers; out_degenerate ORs two of them.
  assign out_valid      = n2_valid;
  assign out_upward_x   = upward_vec[0];
  assign out_upward_y   = upward_vec[1];
  assign out_upward_z   = upward_vec[2];
  assign out_fwd_out_x  = n2_side[0*DW +: DW];
  assign out_fwd_out_y  = n2_side[1*DW +: DW];
  assign out_fwd_out_z  = n2_side[2*DW +: DW];
  assign out_right_x    = n2_side[VEC_W + 0*DW +: DW];
  assign out_right_y    = n2_side[VEC_W + 1*DW +: DW];
  assign out_right_z    = n2_side[VEC_W + 2*DW +: DW];
  assign out_degenerate = n2_side[2*VEC_W] | n2_zero;

  // A result word only appears a fixed latency after a word was taken.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result word without a matching input word");

  // A degenerate result always carries a null upward axis.
  a_degen_upward: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_upward_x == '0 && out_upward_y == '0 && out_upward_z == '0))
    else $error("degenerate result with a nonzero upward axis");

  // A regular result always has a nonzero right axis.
  a_right_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_degenerate) |->
      (out_right_x != '0 || out_right_y != '0 || out_right_z != '0))
    else $error("regular result with a null right axis");

endmodule

// ===== rtl/onb_cross.sv =====
// Four-stage pipelined cross product a x b with operand range reduction.
module onb_cross #(
  parameter int IW     = 32,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [2:0][IW-1:0]         in_a,
  input  logic [2:0][IW-1:0]         in_b,
  input  logic [SIDE_W-1:0]          in_side,
  output onb_pkg::cross_bus_t        out_bus,
  output logic [SIDE_W-1:0]          out_side
);

  localparam int SW  = $clog2(IW + 1);
  localparam int RW  = onb_pkg::RED_W;
  localparam int PW  = 2 * RW + 2;
  localparam int XW  = IW + RW;

  // Stage 1: magnitudes, signs and the reduction shift of each operand.
  logic [IW-1:0] s1_mag_a_r [3];
  logic [IW-1:0] s1_mag_b_r [3];
  logic [2:0]    s1_neg_a_r, s1_neg_b_r;
  logic [SW-1:0] s1_sh_a_r, s1_sh_b_r;
  logic [SW-1:0] sh_a_nxt, sh_b_nxt;
  logic [SIDE_W-1:0] s1_side_r;
  logic          s1_v_r;

  logic [IW-1:0] mag_a [3];
  logic [IW-1:0] mag_b [3];
  logic [IW-1:0] or_a, or_b;
  logic [SW-1:0] len_a, len_b;

  always_comb begin
    or_a  = '0;
    or_b  = '0;
    len_a = '0;
    len_b = '0;
    for (int i = 0; i < 3; i++) begin
      mag_a[i] = in_a[i][IW-1] ? (~in_a[i] + 1'b1) : in_a[i];
      mag_b[i] = in_b[i][IW-1] ? (~in_b[i] + 1'b1) : in_b[i];
      or_a     = or_a | mag_a[i];
      or_b     = or_b | mag_b[i];
    end
    for (int k = 0; k < IW; k++) begin
      if (or_a[k]) len_a = SW'(k + 1);
      if (or_b[k]) len_b = SW'(k + 1);
    end
    sh_a_nxt = (len_a > SW'(RW)) ? (len_a - SW'(RW)) : '0;
    sh_b_nxt = (len_b > SW'(RW)) ? (len_b - SW'(RW)) : '0;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_mag_a_r[i] <= mag_a[i];
      s1_mag_b_r[i] <= mag_b[i];
      s1_neg_a_r[i] <= in_a[i][IW-1];
      s1_neg_b_r[i] <= in_b[i][IW-1];
    end
    s1_sh_a_r <= sh_a_nxt;
    s1_sh_b_r <= sh_b_nxt;
    s1_side_r <= in_side;
  end

  // Stage 2: reduced signed operands.
  logic signed [RW:0] s2_a_r [3];
  logic signed [RW:0] s2_b_r [3];
  logic [SIDE_W-1:0]  s2_side_r;
  logic               s2_v_r;
  logic [XW-1:0]      ext_a [3];
  logic [XW-1:0]      ext_b [3];
  logic [RW:0]        red_a [3];
  logic [RW:0]        red_b [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext_a[i] = XW'(s1_mag_a_r[i] >> s1_sh_a_r);
      ext_b[i] = XW'(s1_mag_b_r[i] >> s1_sh_b_r);
      red_a[i] = {1'b0, ext_a[i][RW-1:0]};
      red_b[i] = {1'b0, ext_b[i][RW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_a_r[i] <= s1_neg_a_r[i] ? -$signed(red_a[i]) : $signed(red_a[i]);
      s2_b_r[i] <= s1_neg_b_r[i] ? -$signed(red_b[i]) : $signed(red_b[i]);
    end
    s2_side_r <= s1_side_r;
  end

  // Stage 3: the six partial products.
  logic signed [PW-1:0] s3_p_r [6];
  logic [SIDE_W-1:0]    s3_side_r;
  logic                 s3_v_r;

  always_ff @(posedge clk) begin
    s3_p_r[0] <= s2_a_r[1] * s2_b_r[2];
    s3_p_r[1] <= s2_a_r[2] * s2_b_r[1];
    s3_p_r[2] <= s2_a_r[2] * s2_b_r[0];
    s3_p_r[3] <= s2_a_r[0] * s2_b_r[2];
    s3_p_r[4] <= s2_a_r[0] * s2_b_r[1];
    s3_p_r[5] <= s2_a_r[1] * s2_b_r[0];
    s3_side_r <= s2_side_r;
  end

  // Stage 4: differences.
  onb_pkg::cross_bus_t s4_bus_r;
  logic [SIDE_W-1:0]   s4_side_r;

  always_ff @(posedge clk) begin
    s4_bus_r.x <= onb_pkg::CROSS_W'(s3_p_r[0]) - onb_pkg::CROSS_W'(s3_p_r[1]);
    s4_bus_r.y <= onb_pkg::CROSS_W'(s3_p_r[2]) - onb_pkg::CROSS_W'(s3_p_r[3]);
    s4_bus_r.z <= onb_pkg::CROSS_W'(s3_p_r[4]) - onb_pkg::CROSS_W'(s3_p_r[5]);
    s4_side_r  <= s3_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      s3_v_r         <= 1'b0;
      s4_bus_r.valid <= 1'b0;
    end else begin
      s1_v_r         <= in_valid;
      s2_v_r         <= s1_v_r;
      s3_v_r         <= s2_v_r;
      s4_bus_r.valid <= s3_v_r;
    end
  end

  assign out_bus  = s4_bus_r;
  assign out_side = s4_side_r;

endmodule

// ===== rtl/onb_norm.sv =====
// Pipelined vector normalization: scale, sum of squares, square root, divide, saturate.
module onb_norm #(
  parameter int DW     = 32,
  parameter int FB     = 16,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  onb_pkg::cross_bus_t  in_bus,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [2:0][DW-1:0]   out_vec,
  output logic                 out_zero,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int MW    = onb_pkg::MAG_W;
  localparam int LW    = onb_pkg::LEN_W;
  localparam int UW    = onb_pkg::UNIT_W;
  localparam int SUMW  = onb_pkg::SUM_W;
  localparam int RTW   = onb_pkg::ROOT_W;
  localparam int QB    = FB + 1;
  localparam int NW    = UW + 1 + FB;
  localparam int CAR_W = SIDE_W + 4 + 3 * UW;
  localparam int RC_W  = SIDE_W + 4;
  localparam int EW    = ((QB > DW) ? QB : DW) + 1;
  localparam logic [EW-1:0] POS_MAX = (EW'(1) << (DW - 1)) - EW'(1);
  localparam logic [EW-1:0] NEG_MAX = EW'(1) << (DW - 1);

  // N1: magnitudes and bit length of the largest one.
  onb_pkg::cross_t comp [3];
  logic [MW-1:0] mag [3];
  logic [MW-1:0] mag_or;
  logic [LW-1:0] len_nxt;
  logic [MW-1:0] n1_mag_r [3];
  logic [2:0]    n1_neg_r;
  logic [LW-1:0] n1_len_r;
  logic [SIDE_W-1:0] n1_side_r;
  logic          n1_v_r;

  always_comb begin
    comp[0] = in_bus.x;
    comp[1] = in_bus.y;
    comp[2] = in_bus.z;
    mag_or  = '0;
    len_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i][onb_pkg::CROSS_W-1] ? MW'(-comp[i]) : MW'(comp[i]);
      mag_or = mag_or | mag[i];
    end
    for (int k = 0; k < MW; k++) begin
      if (mag_or[k]) len_nxt = LW'(k + 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n1_mag_r[i] <= mag[i];
      n1_neg_r[i] <= comp[i][onb_pkg::CROSS_W-1];
    end
    n1_len_r  <= len_nxt;
    n1_side_r <= in_side;
  end

  // N2: one power-of-two scale puts the largest magnitude in [2^30, 2^31).
  logic [MW-1:0]    scaled [3];
  logic [CAR_W-1:0] n2_car_r;
  logic             n2_v_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (n1_len_r > LW'(UW)) begin
        scaled[i] = n1_mag_r[i] >> (n1_len_r - LW'(UW));
      end else begin
        scaled[i] = n1_mag_r[i] << (LW'(UW) - n1_len_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    n2_car_r <= {n1_side_r, (n1_len_r == '0), n1_neg_r,
                 scaled[2][UW-1:0], scaled[1][UW-1:0], scaled[0][UW-1:0]};
  end

  // N3: squares.
  logic [2*UW-1:0]  n3_sq_r [3];
  logic [CAR_W-1:0] n3_car_r;
  logic             n3_v_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n3_sq_r[i] <= n2_car_r[i*UW +: UW] * n2_car_r[i*UW +: UW];
    end
    n3_car_r <= n2_car_r;
  end

  // Square root pipeline, one root bit per stage; index 0 holds the sum.
  logic [SUMW-1:0]  sq_n_r    [0:RTW];
  logic [RTW+1:0]   sq_rem_r  [0:RTW];
  logic [RTW-1:0]   sq_root_r [0:RTW];
  logic [CAR_W-1:0] sq_car_r  [0:RTW];
  logic             sq_v_r    [0:RTW];

  always_ff @(posedge clk) begin
    sq_n_r[0]    <= SUMW'(n3_sq_r[0]) + SUMW'(n3_sq_r[1]) + SUMW'(n3_sq_r[2]);
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_car_r[0]  <= n3_car_r;
  end

  for (genvar j = 1; j <= RTW; j++) begin : g_sqrt
    logic [RTW+3:0] t;
    logic [RTW+3:0] trial;
    logic           ge;

    always_comb begin
      t     = {sq_rem_r[j-1], sq_n_r[j-1][SUMW-1 -: 2]};
      trial = {2'b00, sq_root_r[j-1], 2'b01};
      ge    = (t >= trial);
    end

    always_ff @(posedge clk) begin
      sq_rem_r[j]  <= ge ? (RTW+2)'(t - trial) : t[RTW+1:0];
      sq_root_r[j] <= {sq_root_r[j-1][RTW-2:0], ge};
      sq_n_r[j]    <= sq_n_r[j-1] << 2;
      sq_car_r[j]  <= sq_car_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j] <= 1'b0;
      end else begin
        sq_v_r[j] <= sq_v_r[j-1];
      end
    end
  end

  // Divider pipeline, three lanes, one quotient bit per stage.
  logic [RTW-1:0]  dv_rem_r [0:QB][3];
  logic [QB-1:0]   dv_lo_r  [0:QB][3];
  logic [QB-1:0]   dv_q_r   [0:QB][3];
  logic [RTW-1:0]  dv_len_r [0:QB];
  logic [RC_W-1:0] dv_car_r [0:QB];
  logic            dv_v_r   [0:QB];
  logic [NW-1:0]   num [3];

  // Rounding adds half the divisor to the numerator.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NW'({sq_car_r[RTW][i*UW +: UW], {FB{1'b0}}}) +
               NW'(sq_root_r[RTW] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= RTW'(num[i][NW-1:QB]);
      dv_lo_r[0][i]  <= num[i][QB-1:0];
      dv_q_r[0][i]   <= '0;
    end
    dv_len_r[0] <= sq_root_r[RTW];
    dv_car_r[0] <= sq_car_r[RTW][CAR_W-1:3*UW];
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [RTW:0] t;
      logic         ge;

      always_comb begin
        t  = {dv_rem_r[k-1][i], dv_lo_r[k-1][i][QB-1]};
        ge = (t >= {1'b0, dv_len_r[k-1]});
      end

      always_ff @(posedge clk) begin
        dv_rem_r[k][i] <= ge ? RTW'(t - {1'b0, dv_len_r[k-1]}) : t[RTW-1:0];
        dv_lo_r[k][i]  <= dv_lo_r[k-1][i] << 1;
        dv_q_r[k][i]   <= {dv_q_r[k-1][i][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      dv_len_r[k] <= dv_len_r[k-1];
      dv_car_r[k] <= dv_car_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
    end
  end

  // Final stage: restore sign, saturate, force zero for a null vector.
  logic [EW-1:0]     qe [3];
  logic [2:0][DW-1:0] vec_nxt;
  logic              zero_f;
  logic [2:0]        neg_f;
  logic [2:0][DW-1:0] out_vec_r;
  logic              out_zero_r;
  logic [SIDE_W-1:0] out_side_r;
  logic              out_v_r;

  always_comb begin
    zero_f = dv_car_r[QB][3];
    neg_f  = dv_car_r[QB][2:0];
    for (int i = 0; i < 3; i++) begin
      qe[i] = EW'(dv_q_r[QB][i]);
      if (zero_f) begin
        vec_nxt[i] = '0;
      end else if (!neg_f[i]) begin
        vec_nxt[i] = (qe[i] > POS_MAX) ? {1'b0, {(DW-1){1'b1}}} : qe[i][DW-1:0];
      end else begin
        vec_nxt[i] = (qe[i] > NEG_MAX) ? {1'b1, {(DW-1){1'b0}}} : (~qe[i][DW-1:0] + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_vec_r  <= vec_nxt;
    out_zero_r <= zero_f;
    out_side_r <= dv_car_r[QB][RC_W-1:4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_v_r    <= 1'b0;
      n2_v_r    <= 1'b0;
      n3_v_r    <= 1'b0;
      sq_v_r[0] <= 1'b0;
      dv_v_r[0] <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      n1_v_r    <= in_bus.valid;
      n2_v_r    <= n1_v_r;
      n3_v_r    <= n2_v_r;
      sq_v_r[0] <= n3_v_r;
      dv_v_r[0] <= sq_v_r[RTW];
      out_v_r   <= dv_v_r[QB];
    end
  end

  assign out_valid = out_v_r;
  assign out_vec   = out_vec_r;
  assign out_zero  = out_zero_r;
  assign out_side  = out_side_r;

endmodule

// ===== tb/orthonormal_basis_from_up_unit_tb.sv =====
// Testbench for the orthonormal basis unit: directed and random forward vectors, self-checked.
module orthonormal_basis_from_up_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 32;
  localparam int FB = 16;
  // Pipeline latency of the unit, plus slack.
  localparam int SETTLE_CYCLES = 2 * (43 + FB) + 12;
  // Cycles without an accepted word, a result or a cfg write before the run is declared hung.
  localparam int HANG_LIMIT = 4000;
  // A register index past the last up vector register; writes to it are dropped.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [DW-1:0] ONE_Q = 32'h0001_0000;
  localparam logic [DW-1:0] MAX_Q = 32'h7fff_ffff;
  localparam logic [DW-1:0] MIN_Q = 32'h8000_0000;

  typedef longint vec_t [3];

  typedef struct {
    logic [DW-1:0] right_x, right_y, right_z;
    logic [DW-1:0] upward_x, upward_y, upward_z;
    logic [DW-1:0] fwd_x, fwd_y, fwd_z;
    logic          degenerate;
  } basis_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [DW-1:0] in_fwd_x = '0, in_fwd_y = '0, in_fwd_z = '0;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = '0;
  logic [DW-1:0] cfg_wdata = '0;
  logic          out_valid;
  logic [DW-1:0] out_right_x, out_right_y, out_right_z;
  logic [DW-1:0] out_upward_x, out_upward_y, out_upward_z;
  logic [DW-1:0] out_fwd_out_x, out_fwd_out_y, out_fwd_out_z;
  logic          out_degenerate;

  // The predictor's own copy of the up vector registers.
  logic [DW-1:0] up_reg [3];
  basis_t        pending_bases [$];
  int            error_count = 0;
  int            words_sent = 0;
  int            bases_checked = 0;
  int            degenerate_seen = 0;
  int            idle_cycles = 0;

  orthonormal_basis_from_up_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (.*);

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Basis predictor, exact integer arithmetic.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // Shift every component right by the fewest bits that bring all magnitudes
  // below 2^30, truncating magnitudes and keeping signs.
  function automatic vec_t shrink(vec_t v);
    longint unsigned m = 0;
    int s = 0;
    vec_t r;
    for (int i = 0; i < 3; i++) if (magnitude(v[i]) > m) m = magnitude(v[i]);
    while ((m >> s) >= (64'd1 << onb_pkg::RED_W)) s++;
    for (int i = 0; i < 3; i++) begin
      r[i] = longint'(magnitude(v[i]) >> s);
      if (v[i] < 0) r[i] = -r[i];
    end
    return r;
  endfunction

  function automatic vec_t cross_exact(vec_t a, vec_t b);
    vec_t ra, rb, c;
    ra = shrink(a);
    rb = shrink(b);
    c[0] = ra[1] * rb[2] - ra[2] * rb[1];
    c[1] = ra[2] * rb[0] - ra[0] * rb[2];
    c[2] = ra[0] * rb[1] - ra[1] * rb[0];
    return c;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Unit vector in Q format; returns 1 when c has zero length (o all zero).
  function automatic bit unit_vector(vec_t c, output vec_t o);
    longint unsigned a [3];
    longint unsigned m = 0, sum = 0, len, q;
    longint v;
    int rs = 0, ls = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = magnitude(c[i]);
      if (a[i] > m) m = a[i];
    end
    o = '{0, 0, 0};
    if (m == 0) return 1'b1;
    while ((m >> rs) >= (64'd1 << 31)) rs++;
    while ((m << ls) < (64'd1 << 30)) ls++;
    for (int i = 0; i < 3; i++) begin
      a[i] = (a[i] >> rs) << ls;
      sum += a[i] * a[i];
    end
    len = int_root(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << FB) + (len >> 1)) / len;
      v = (c[i] < 0) ? -longint'(q) : longint'(q);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      o[i] = v;
    end
    return 1'b0;
  endfunction

  function automatic basis_t predict_basis(logic [DW-1:0] fx, logic [DW-1:0] fy,
                                           logic [DW-1:0] fz);
    vec_t up, fwd, x, y;
    basis_t b;
    bit deg;
    for (int i = 0; i < 3; i++) up[i] = longint'($signed(up_reg[i]));
    fwd = '{longint'($signed(fx)), longint'($signed(fy)), longint'($signed(fz))};
    deg = unit_vector(cross_exact(up, fwd), x);
    if (unit_vector(cross_exact(fwd, x), y)) deg = 1'b1;
    b.right_x = x[0][DW-1:0];  b.right_y = x[1][DW-1:0];  b.right_z = x[2][DW-1:0];
    b.upward_x = y[0][DW-1:0]; b.upward_y = y[1][DW-1:0]; b.upward_z = y[2][DW-1:0];
    b.fwd_x = fx; b.fwd_y = fy; b.fwd_z = fz;
    b.degenerate = deg;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Sends one forward vector word after a random gap, which may be empty. start is
  // only lowered when a gap follows, so it never drops and rises in one step.
  task automatic send_word(logic [DW-1:0] fx, logic [DW-1:0] fy, logic [DW-1:0] fz);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_fwd_x <= fx;
    in_fwd_y <= fy;
    in_fwd_z <= fz;
    do @(posedge clk); while (busy);
    pending_bases.push_back(predict_basis(fx, fy, fz));
    words_sent++;
  endtask

  // Lowers start and waits until every expected basis has come out, then lets
  // the pipeline settle so the up vector can be changed safely.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (pending_bases.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three up vector registers on consecutive edges, then a write to
  // the unused index, which must leave the registers alone.
  task automatic write_up_vector(logic [DW-1:0] ux, logic [DW-1:0] uy, logic [DW-1:0] uz);
    logic [DW-1:0] vals [3];
    onb_pkg::cfg_reg_t idx [3];
    vals = '{ux, uy, uz};
    idx = '{onb_pkg::REG_UP_X, onb_pkg::REG_UP_Y, onb_pkg::REG_UP_Z};
    cfg_we <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      up_reg[i] = vals[i];
    end
    cfg_index <= REG_UNUSED;
    cfg_wdata <= DW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A random component: mostly full range, sometimes small, zero or extreme.
  function automatic logic [DW-1:0] random_component();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ($urandom_range(0, 1) != 0) ? MAX_Q : MIN_Q;
      2, 3:    return DW'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return DW'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------------

  // Axis-aligned, parallel, zero and extreme forward vectors under the reset up vector.
  task automatic test_directed_vectors();
    send_word('0, '0, ONE_Q);
    send_word(ONE_Q, '0, '0);
    send_word('0, ONE_Q, '0);            // parallel to up: degenerate
    send_word('0, -ONE_Q, '0);           // anti-parallel to up: degenerate
    send_word('0, '0, '0);               // zero forward: degenerate
    send_word(MAX_Q, MAX_Q, MAX_Q);
    send_word(MIN_Q, MIN_Q, MIN_Q);
    send_word(MIN_Q, MAX_Q, MIN_Q);
    send_word(MAX_Q, '0, MIN_Q);
    send_word(32'd1, '0, 32'hffff_ffff); // smallest nonzero magnitudes
    send_word(32'hffff_ffff, 32'd1, '0);
    send_word(ONE_Q, ONE_Q, ONE_Q);
    send_word(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
    drain_pipeline();
  endtask

  // Up vectors at the extremes of the register range, including the zero vector.
  task automatic test_up_extremes();
    write_up_vector(MAX_Q, MIN_Q, 32'd1);
    send_word('0, '0, ONE_Q);
    send_word(MAX_Q, MIN_Q, 32'd1);      // parallel to up: degenerate
    send_word(MIN_Q, MAX_Q, '0);
    send_word(32'd1, 32'd1, 32'hffff_ffff);
    drain_pipeline();
    write_up_vector('0, '0, '0);         // every basis is degenerate
    send_word(ONE_Q, 32'h1234_5678, MIN_Q);
    send_word(MAX_Q, MAX_Q, MAX_Q);
    drain_pipeline();
  endtask

  // Random forward vectors under several up vectors. Some words reuse the up
  // direction, scaled, so the degenerate path is hit in the random part as well.
  task automatic test_random_vectors(int count);
    logic [DW-1:0] ux, uy, uz, sx, sy, sz;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin ux = '0; uy = ONE_Q; uz = '0; end
        1:       begin ux = MIN_Q; uy = MIN_Q; uz = MAX_Q; end
        default: begin ux = random_component(); uy = random_component();
                       uz = random_component(); end
      endcase
      write_up_vector(ux, uy, uz);
      for (int n = 0; n < count / 4; n++) begin
        if ($urandom_range(0, 19) == 0) begin
          sx = $signed(ux) >>> 1; sy = $signed(uy) >>> 1; sz = $signed(uz) >>> 1;
          send_word(sx, sy, sz);
        end else begin
          send_word(random_component(), random_component(), random_component());
        end
      end
      drain_pipeline();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so every out_valid is one basis.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    basis_t b;
    if (rst_n && out_valid) begin
      if (pending_bases.size() == 0) begin
        $display("%0t: basis came out with none expected", $time);
        error_count++;
      end else begin
        b = pending_bases.pop_front();
        check_field("right_x", b.right_x, out_right_x);
        check_field("right_y", b.right_y, out_right_y);
        check_field("right_z", b.right_z, out_right_z);
        check_field("upward_x", b.upward_x, out_upward_x);
        check_field("upward_y", b.upward_y, out_upward_y);
        check_field("upward_z", b.upward_z, out_upward_z);
        check_field("fwd_out_x", b.fwd_x, out_fwd_out_x);
        check_field("fwd_out_y", b.fwd_y, out_fwd_out_y);
        check_field("fwd_out_z", b.fwd_z, out_fwd_out_z);
        check_field("degenerate", DW'(b.degenerate), DW'(out_degenerate));
        if (b.degenerate) degenerate_seen++;
        bases_checked++;
      end
    end
  end

  // Watchdog: counts cycles in which no word goes in or comes out and no cfg write is made.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    up_reg = '{'0, ONE_Q, '0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_vectors();
    test_up_extremes();
    test_random_vectors(1000);
    $display("Checked %0d bases from %0d forward words under 7 up vectors,", bases_checked,
             words_sent);
    $display("%0d of them degenerate, with %0d mismatches.", degenerate_seen, error_count);
    if (error_count == 0 && pending_bases.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
